FILE: src/rmh_pkg.sv
package rmh_pkg;

    localparam int unsigned CAPACITY_DEF     = 1024;
    localparam int unsigned SAMPLE_WIDTH_DEF = 32;
    localparam int unsigned MEDIAN_W         = 32;
    localparam int unsigned SEEN_W           = 11;

endpackage

FILE: src/rmh_if.sv
interface rmh_in_if #(parameter int unsigned SW = 32);
    logic          valid;
    logic          ready;
    logic [SW-1:0] sample;
    logic          new_set;
    modport source (output valid, output sample, output new_set, input ready);
    modport sink   (input valid, input sample, input new_set, output ready);
endinterface

interface rmh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] median;
    logic [10:0] samples_seen;
    logic        overflow;
    modport source (output valid, output median, output samples_seen, output overflow,
                    input ready);
    modport sink   (input valid, input median, input samples_seen, input overflow,
                    output ready);
endinterface

FILE: src/running_median_two_heaps_unit.sv
// Running median over a stream of signed samples, kept in two heaps.
// Input channel (rmh_in_if): sample plus new_set; new_set empties both
// heaps and clears the held median before the sample is taken.
// Output channel (rmh_out_if): median, samples_seen, overflow. A result
// comes after every odd-numbered sample of a set; an even count gives none.
// A full set drops the sample and returns the last median with overflow set,
// loaded into the output register by the emit state that the transfer leads to.
// Each heap is one synchronous RAM with one read and one write per cycle.
// An item is inserted by a sift-up; if the upper heap then holds more than one
// entry over the lower, or the lower more than the upper, the larger heap pops
// its top with a sift-down and a second push moves that top to the other heap.
// One item is worked at a time; the input is ready again when the result is
// loaded, or when an item with an even count ends without one.
// The result sits in an output register; while the receiver stalls the
// block still accepts the next item and works it, waiting only when a new
// result would need the still-full output register.
// Reset (synchronous, active low) empties both heaps and clears the held
// median; RAM contents stay undefined and are never used before written.
module running_median_two_heaps_unit #(
    parameter int unsigned CAPACITY     = rmh_pkg::CAPACITY_DEF,
    parameter int unsigned SAMPLE_WIDTH = rmh_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rmh_in_if.sink    i_in,
    rmh_out_if.source o_out
);
    import rmh_pkg::*;

    localparam int unsigned HALF = (CAPACITY + 1) / 2 + 1;
    localparam int unsigned AW   = $clog2(HALF);
    localparam int unsigned CW   = $clog2(HALF + 1);
    localparam int unsigned TW   = $clog2(CAPACITY + 1);
    localparam int unsigned XW   = AW + 2;
    localparam int unsigned SW   = SAMPLE_WIDTH;

    localparam logic [SW-1:0] SIGN_MASK = {1'b1, {(SW-1){1'b0}}};

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_TOPRD = 5'd1;
    localparam logic [4:0] S_TOPWT = 5'd2;
    localparam logic [4:0] S_PUSH  = 5'd3;
    localparam logic [4:0] S_PCMP  = 5'd4;
    localparam logic [4:0] S_PFIN  = 5'd5;
    localparam logic [4:0] S_BAL   = 5'd6;
    localparam logic [4:0] S_POP0  = 5'd7;
    localparam logic [4:0] S_POP1  = 5'd8;
    localparam logic [4:0] S_POP2  = 5'd9;
    localparam logic [4:0] S_PCH1  = 5'd10;
    localparam logic [4:0] S_PCH2  = 5'd11;
    localparam logic [4:0] S_PDEC  = 5'd12;
    localparam logic [4:0] S_POPF  = 5'd13;
    localparam logic [4:0] S_MRD   = 5'd14;
    localparam logic [4:0] S_MWT   = 5'd15;
    localparam logic [4:0] S_EMIT  = 5'd16;

    // heap storage, order keys (sample with its sign bit flipped)
    logic [SW-1:0] mem_upper [HALF];
    logic [SW-1:0] mem_lower [HALF];

    logic [4:0]          r_state;
    logic                r_sel;      // 1: lower (max) heap, 0: upper (min) heap
    logic                r_second;   // working the rebalance push
    logic [SW-1:0]       r_pkey;
    logic [SW-1:0]       r_ptop;
    logic [SW-1:0]       r_lastv;
    logic [SW-1:0]       r_cval;
    logic [SW-1:0]       r_rdu;
    logic [SW-1:0]       r_rdl;
    logic [CW-1:0]       r_ucnt, r_lcnt;
    logic [CW-1:0]       r_n;
    logic [AW-1:0]       r_idx;
    logic [AW-1:0]       r_cidx;
    logic [MEDIAN_W-1:0] r_last;
    logic                r_ovf;
    logic [TW-1:0]       r_total;
    logic                r_ovalid;
    logic [MEDIAN_W-1:0] r_omed;
    logic [SEEN_W-1:0]   r_oseen;
    logic                r_oovf;

    logic          s_accept;
    logic          s_oaccept;
    logic [TW:0]   s_sum;
    logic [TW:0]   s_tot;
    logic          s_full;
    logic [CW-1:0] s_cnt;
    logic [SW-1:0] s_rd;
    logic [AW-1:0] s_pidx;
    logic [AW-1:0] s_ppar;
    logic [AW-1:0] s_par;
    logic [AW-1:0] s_gpar;
    logic [XW-1:0] s_sib;
    logic [XW-1:0] s_nc;
    logic [XW-1:0] s_nx;
    logic          s_up;
    logic          s_dn;
    logic          s_sw;
    logic          s_bal_u;
    logic          s_bal_l;
    logic [4:0]    s_after;
    logic          s_ren;
    logic [AW-1:0] s_raddr;
    logic          s_wen;
    logic [AW-1:0] s_waddr;
    logic [SW-1:0] s_wdata;

    // true when key a belongs nearer the root than key b
    function automatic logic above(input logic [SW-1:0] a, input logic [SW-1:0] b,
                                   input logic maxh);
        return maxh ? (a > b) : (a < b);
    endfunction

    assign s_accept   = i_in.valid && i_in.ready;
    assign s_oaccept  = r_ovalid && o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // counts, indexes and compares
    assign s_sum   = (TW+1)'(r_ucnt) + (TW+1)'(r_lcnt);
    assign s_tot   = i_in.new_set ? '0 : s_sum;
    assign s_full  = s_tot >= (TW+1)'(CAPACITY);
    assign s_cnt   = r_sel ? r_lcnt : r_ucnt;
    assign s_rd    = r_sel ? r_rdl : r_rdu;
    assign s_pidx  = AW'(s_cnt);
    assign s_ppar  = (s_pidx - AW'(1)) >> 1;
    assign s_par   = (r_idx - AW'(1)) >> 1;
    assign s_gpar  = (s_par - AW'(1)) >> 1;
    assign s_sib   = XW'(r_cidx) + XW'(1);
    assign s_nc    = XW'({r_cidx, 1'b1});
    assign s_nx    = XW'(r_n);
    assign s_up    = above(r_pkey, s_rd, r_sel);
    assign s_dn    = above(r_cval, r_lastv, r_sel);
    assign s_sw    = above(s_rd, r_cval, r_sel);
    assign s_bal_u = (CW+1)'(r_ucnt) > (CW+1)'(r_lcnt) + (CW+1)'(1);
    assign s_bal_l = r_lcnt > r_ucnt;
    assign s_after = r_second ? S_MRD : S_BAL;

    // heap RAM read and write requests
    always_comb begin
        s_ren   = 1'b0;
        s_raddr = '0;
        s_wen   = 1'b0;
        s_waddr = '0;
        s_wdata = r_pkey;
        unique case (r_state)
            S_TOPRD, S_MRD, S_POP0: begin
                s_ren = 1'b1;
            end
            S_PUSH: begin
                if (s_cnt == '0) begin
                    s_wen = 1'b1;
                end else begin
                    s_ren   = 1'b1;
                    s_raddr = s_ppar;
                end
            end
            S_PCMP: begin
                s_wen   = 1'b1;
                s_waddr = r_idx;
                if (s_up) begin
                    s_wdata = s_rd;
                    if (s_par != '0) begin
                        s_ren   = 1'b1;
                        s_raddr = s_gpar;
                    end
                end
            end
            S_PFIN: begin
                s_wen = 1'b1;
            end
            S_POP1: begin
                s_ren   = 1'b1;
                s_raddr = AW'(r_n);
            end
            S_POP2: begin
                if (r_n > CW'(1)) begin
                    s_ren   = 1'b1;
                    s_raddr = AW'(1);
                end
            end
            S_PCH1: begin
                if (s_sib < s_nx) begin
                    s_ren   = 1'b1;
                    s_raddr = AW'(s_sib);
                end
            end
            S_PDEC: begin
                if (s_dn) begin
                    s_wen   = 1'b1;
                    s_waddr = r_idx;
                    s_wdata = r_cval;
                    if (s_nc < s_nx) begin
                        s_ren   = 1'b1;
                        s_raddr = AW'(s_nc);
                    end
                end
            end
            S_POPF: begin
                if (r_n != '0) begin
                    s_wen   = 1'b1;
                    s_waddr = r_idx;
                    s_wdata = r_lastv;
                end
            end
            default: begin
                s_ren = 1'b0;
            end
        endcase
    end

    // heap RAMs, registered read
    always_ff @(posedge i_clk) begin
        if (s_ren) begin
            r_rdu <= mem_upper[s_raddr];
            r_rdl <= mem_lower[s_raddr];
        end
        if (s_wen) begin
            if (r_sel) mem_lower[s_waddr] <= s_wdata;
            else       mem_upper[s_waddr] <= s_wdata;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ucnt   <= '0;
            r_lcnt   <= '0;
            r_last   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (s_oaccept) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_pkey   <= i_in.sample ^ SIGN_MASK;
                        r_second <= 1'b0;
                        r_total  <= TW'(s_tot);
                        r_ovf    <= s_full;
                        if (i_in.new_set) begin
                            r_ucnt <= '0;
                            r_lcnt <= '0;
                            r_last <= '0;
                        end
                        if (s_full) begin
                            r_state <= S_EMIT;
                        end else if (i_in.new_set || r_ucnt == '0) begin
                            r_sel   <= 1'b0;
                            r_state <= S_PUSH;
                        end else begin
                            r_state <= S_TOPRD;
                        end
                    end
                end
                S_TOPRD: r_state <= S_TOPWT;
                S_TOPWT: begin
                    // below the upper top goes to the lower heap
                    r_sel   <= (r_pkey < r_rdu);
                    r_state <= S_PUSH;
                end
                // sift-up: one level per cycle
                S_PUSH: begin
                    if (r_sel) r_lcnt <= r_lcnt + CW'(1);
                    else       r_ucnt <= r_ucnt + CW'(1);
                    r_idx   <= s_pidx;
                    r_state <= (s_cnt == '0) ? s_after : S_PCMP;
                end
                S_PCMP: begin
                    if (s_up) begin
                        r_idx <= s_par;
                        if (s_par == '0) r_state <= S_PFIN;
                    end else begin
                        r_state <= s_after;
                    end
                end
                S_PFIN: r_state <= s_after;
                S_BAL: begin
                    if (s_bal_u) begin
                        r_sel   <= 1'b0;
                        r_state <= S_POP0;
                    end else if (s_bal_l) begin
                        r_sel   <= 1'b1;
                        r_state <= S_POP0;
                    end else begin
                        r_state <= S_MRD;
                    end
                end
                // pop: fetch root and last entry, then sift-down
                S_POP0: begin
                    r_n <= s_cnt - CW'(1);
                    if (r_sel) r_lcnt <= r_lcnt - CW'(1);
                    else       r_ucnt <= r_ucnt - CW'(1);
                    r_state <= S_POP1;
                end
                S_POP1: begin
                    r_ptop  <= s_rd;
                    r_state <= S_POP2;
                end
                S_POP2: begin
                    r_lastv <= s_rd;
                    r_idx   <= '0;
                    if (r_n > CW'(1)) begin
                        r_cidx  <= AW'(1);
                        r_state <= S_PCH1;
                    end else begin
                        r_state <= S_POPF;
                    end
                end
                S_PCH1: begin
                    r_cval  <= s_rd;
                    r_state <= (s_sib < s_nx) ? S_PCH2 : S_PDEC;
                end
                S_PCH2: begin
                    if (s_sw) begin
                        r_cval <= s_rd;
                        r_cidx <= AW'(s_sib);
                    end
                    r_state <= S_PDEC;
                end
                S_PDEC: begin
                    if (s_dn) begin
                        r_idx <= r_cidx;
                        if (s_nc < s_nx) begin
                            r_cidx  <= AW'(s_nc);
                            r_state <= S_PCH1;
                        end else begin
                            r_state <= S_POPF;
                        end
                    end else begin
                        r_state <= S_POPF;
                    end
                end
                S_POPF: begin
                    // popped top goes to the other heap
                    r_pkey   <= r_ptop;
                    r_sel    <= !r_sel;
                    r_second <= 1'b1;
                    r_state  <= S_PUSH;
                end
                S_MRD: r_state <= S_MWT;
                S_MWT: begin
                    r_total <= TW'(s_sum);
                    r_state <= s_sum[0] ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (!r_ovalid || s_oaccept) begin
                        r_ovalid <= 1'b1;
                        r_oovf   <= r_ovf;
                        r_oseen  <= SEEN_W'(r_total);
                        if (r_ovf) begin
                            r_omed <= r_last;
                        end else begin
                            r_omed <= MEDIAN_W'(r_rdu ^ SIGN_MASK);
                            r_last <= MEDIAN_W'(r_rdu ^ SIGN_MASK);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.median       = r_omed;
    assign o_out.samples_seen = r_oseen;
    assign o_out.overflow     = r_oovf;

endmodule
